[hdl/gbsa_pkg.sv]
// Shared constants, types and command/status structs for the buffer split allocator.
`default_nettype none
package gbsa_pkg;
	localparam int MAX_CHANNELS = 64;
	localparam int CH_W = $clog2(MAX_CHANNELS);
	localparam int CNT_W = 7;
	localparam int DATA_W = 32;
	localparam int SPL_W = DATA_W + 1;
	localparam int SUM_W = DATA_W + CH_W + 1;
	localparam logic [DATA_W-1:0] BUDGET_RST = 32'd41943040;
	localparam logic [CNT_W-1:0] COUNT_RST = 7'd64;
	localparam logic [DATA_W-1:0] MIN_BUFFER = 32'd16;
	localparam logic [DATA_W-1:0] ALIGN_MASK = ~32'd7;

	typedef enum logic {
		REG_BUDGET = 1'b0,
		REG_COUNT  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		RD_CH   = 2'd0,
		RD_IDX  = 2'd1,
		RD_PICK = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		DIV_A = 2'd0,
		DIV_B = 2'd1,
		DIV_C = 2'd2
	} div_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    take_item;
		rd_sel_t rd_sel;
		logic    tot_wr;
		logic    init_wr;
		logic    upd_wr;
		logic    idx_clr;
		logic    idx_inc;
		logic    sum_clr;
		logic    max_clr;
		logic    max_cmp;
		logic    pick_idx;
		logic    pk_load;
		logic    pk_inc;
		logic    div_start;
		logic    div_take;
		div_op_t div_op;
		logic    out_load;
		logic    clear_valid;
	} ctrl_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic sum_ge;
		logic best_zero;
		logic size_nz;
		logic div_done;
		logic out_taken;
	} dp_status_t;
endpackage
`default_nettype wire

[hdl/gbsa_if.sv]
// Handshake interfaces for the item, result and configuration channels.
`default_nettype none
interface gbsa_item_if import gbsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [CH_W-1:0]   channel_index;
	logic [DATA_W-1:0] byte_count;
	modport source (output valid, mode, channel_index, byte_count, input ready);
	modport sink (input valid, mode, channel_index, byte_count, output ready);
endinterface

interface gbsa_result_if import gbsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   out_channel;
	logic [DATA_W-1:0] buffer_size;
	logic [DATA_W-1:0] split_count;
	logic              last_result;
	modport source (output valid, out_channel, buffer_size, split_count, last_result,
		input ready);
	modport sink (input valid, out_channel, buffer_size, split_count, last_result,
		output ready);
endinterface

interface gbsa_cfg_if import gbsa_pkg::*; ();
	logic              valid;
	logic              ready;
	reg_idx_t          index;
	logic [DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/gbsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hdl/gbsa_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gbsa_div import gbsa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DATA_W-1:0] dividend,
	input  wire logic [SPL_W-1:0]  divisor,
	output logic                   done,
	output logic      [DATA_W-1:0] quotient
);
	localparam int STEP_W = $clog2(DATA_W);

	logic [SPL_W-1:0]  rem_q;
	logic [SPL_W-1:0]  dvs_q;
	logic [DATA_W-1:0] dq_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [SPL_W:0]    shifted;
	logic [SPL_W:0]    diff;

	assign shifted = {rem_q, dq_q[DATA_W-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign done = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dq_q <= dividend;
		end else if (busy_q) begin
			if (!diff[SPL_W]) begin
				rem_q <= diff[SPL_W-1:0];
				dq_q <= {dq_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SPL_W-1:0];
				dq_q <= {dq_q[DATA_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[hdl/gbsa_datapath.sv]
// Datapath: channel tables, running sum, best-gain search, divider and result register.
`default_nettype none
module gbsa_datapath import gbsa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output dp_status_t             sts,
	input  wire logic [CH_W-1:0]   item_channel,
	input  wire logic [DATA_W-1:0] item_bytes,
	input  wire logic              cfg_valid,
	input  wire reg_idx_t          cfg_index,
	input  wire logic [DATA_W-1:0] cfg_data,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output logic      [CH_W-1:0]   res_channel,
	output logic      [DATA_W-1:0] res_size,
	output logic      [DATA_W-1:0] res_splits,
	output logic                   res_last
);
	logic [DATA_W-1:0]       budget_q;
	logic [CNT_W-1:0]        count_q;
	logic [CH_W-1:0]         n_last;
	logic [CH_W-1:0]         ch_q;
	logic [DATA_W-1:0]       bytes_q;
	logic [CH_W-1:0]         idx_q;
	logic [CH_W-1:0]         pick_q;
	logic [DATA_W-1:0]       best_q;
	logic [SUM_W-1:0]        sum_q;
	logic [DATA_W-1:0]       tot_q;
	logic [DATA_W-1:0]       sz_q;
	logic [SPL_W-1:0]        k_q;
	logic [DATA_W-1:0]       nsz_q;
	logic [DATA_W-1:0]       q2_q;
	logic [MAX_CHANNELS-1:0] tvalid_q;
	logic                    tv_s1;
	logic                    rv_q;
	logic [CH_W-1:0]         rd_addr;
	logic [CH_W-1:0]         wr_addr;
	logic                    tbl_we;
	logic [DATA_W-1:0]       tot_rdata;
	logic [DATA_W-1:0]       tot_rd;
	logic [DATA_W-1:0]       size_rd;
	logic [SPL_W-1:0]        spl_rd;
	logic [DATA_W-1:0]       gain_rd;
	logic [DATA_W:0]         tot_add;
	logic [DATA_W-1:0]       tot_sat;
	logic [DATA_W-1:0]       size_wd;
	logic [SPL_W-1:0]        spl_wd;
	logic [DATA_W-1:0]       gain_wd;
	logic [SPL_W-1:0]        divisor;
	logic                    div_done;
	logic [DATA_W-1:0]       quotient;
	logic [DATA_W-1:0]       size_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RST;
			count_q <= COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BUDGET: budget_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q == '0) begin
			n_last = '0;
		end else if (count_q > CNT_W'(MAX_CHANNELS)) begin
			n_last = CH_W'(MAX_CHANNELS - 1);
		end else begin
			n_last = CH_W'(count_q - 1'b1);
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_CH: rd_addr = ch_q;
			RD_IDX: rd_addr = idx_q;
			RD_PICK: rd_addr = pick_q;
			default: rd_addr = idx_q;
		endcase
	end

	assign wr_addr = cmd.upd_wr ? pick_q : idx_q;
	assign tbl_we = cmd.init_wr | cmd.upd_wr;
	// A total never loaded since the last run reads as zero.
	assign tot_rd = tv_s1 ? tot_rdata : '0;
	assign tot_add = {1'b0, tot_rd} + {1'b0, bytes_q};
	assign tot_sat = tot_add[DATA_W] ? '1 : tot_add[DATA_W-1:0];
	assign size_wd = cmd.init_wr ? tot_rd : nsz_q;
	assign spl_wd = cmd.init_wr ? SPL_W'(1) : k_q;
	assign gain_wd = cmd.init_wr ? (tot_rd - (tot_rd >> 1)) : (nsz_q - q2_q);

	gbsa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_tot_ram (
		.clk(clk), .we(cmd.tot_wr), .waddr(ch_q), .wdata(tot_sat),
		.raddr(rd_addr), .rdata(tot_rdata)
	);
	gbsa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_size_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_addr), .wdata(size_wd),
		.raddr(rd_addr), .rdata(size_rd)
	);
	gbsa_ram #(.WIDTH(SPL_W), .DEPTH(MAX_CHANNELS)) u_spl_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_addr), .wdata(spl_wd),
		.raddr(rd_addr), .rdata(spl_rd)
	);
	gbsa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_CHANNELS)) u_gain_ram (
		.clk(clk), .we(tbl_we), .waddr(wr_addr), .wdata(gain_wd),
		.raddr(rd_addr), .rdata(gain_rd)
	);

	always_comb begin
		case (cmd.div_op)
			DIV_A: divisor = {1'b0, sz_q};
			DIV_B: divisor = k_q;
			DIV_C: divisor = k_q + 1'b1;
			default: divisor = k_q;
		endcase
	end

	gbsa_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(tot_q),
		.divisor(divisor), .done(div_done), .quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= '0;
			tv_s1 <= 1'b0;
			rv_q <= 1'b0;
			idx_q <= '0;
		end else begin
			tv_s1 <= tvalid_q[rd_addr];
			if (cmd.clear_valid) begin
				tvalid_q <= '0;
			end else if (cmd.tot_wr) begin
				tvalid_q[ch_q] <= 1'b1;
			end
			if (cmd.out_load) begin
				rv_q <= 1'b1;
			end else if (res_ready) begin
				rv_q <= 1'b0;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign size_fix = (size_rd == '0) ? MIN_BUFFER : size_rd;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			ch_q <= item_channel;
			bytes_q <= item_bytes;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.init_wr) begin
			sum_q <= sum_q + SUM_W'(tot_rd);
		end else if (cmd.upd_wr) begin
			sum_q <= sum_q - SUM_W'(sz_q - nsz_q);
		end
		// Strictly greater keeps the lowest index on a tie.
		if (cmd.max_clr) begin
			best_q <= '0;
			pick_q <= '0;
		end else if (cmd.max_cmp && (gain_rd > best_q)) begin
			best_q <= gain_rd;
			pick_q <= idx_q;
		end else if (cmd.pick_idx) begin
			pick_q <= idx_q;
		end
		if (cmd.pk_load) begin
			tot_q <= tot_rd;
			sz_q <= size_rd;
			k_q <= cmd.pk_inc ? (spl_rd + 1'b1) : spl_rd;
		end else if (cmd.div_take) begin
			case (cmd.div_op)
				DIV_A: k_q <= {1'b0, quotient};
				DIV_B: nsz_q <= quotient;
				DIV_C: q2_q <= quotient;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			res_channel <= idx_q;
			res_size <= size_fix & ALIGN_MASK;
			res_splits <= spl_rd[SPL_W-1] ? '1 : spl_rd[DATA_W-1:0];
			res_last <= (idx_q == n_last);
		end
	end

	assign res_valid = rv_q;

	assign sts.idx_last = (idx_q == n_last);
	assign sts.sum_ge = (sum_q >= SUM_W'(budget_q));
	assign sts.best_zero = (best_q == '0);
	assign sts.size_nz = (size_rd != '0);
	assign sts.div_done = div_done;
	assign sts.out_taken = rv_q & res_ready;
endmodule
`default_nettype wire

[hdl/gbsa_ctrl.sv]
// Controller state machine sequencing loads, the split loop and result emission.
`default_nettype none
module gbsa_ctrl import gbsa_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic       item_mode,
	input  wire dp_status_t sts,
	output ctrl_cmd_t       cmd
);
	typedef enum logic [22:0] {
		S_IDLE    = 23'd1 << 0,
		S_LD_RD   = 23'd1 << 1,
		S_LD_WR   = 23'd1 << 2,
		S_INIT_RD = 23'd1 << 3,
		S_INIT_WR = 23'd1 << 4,
		S_CHECK   = 23'd1 << 5,
		S_MAX_RD  = 23'd1 << 6,
		S_MAX_CMP = 23'd1 << 7,
		S_MAX_END = 23'd1 << 8,
		S_NZ_RD   = 23'd1 << 9,
		S_NZ_CMP  = 23'd1 << 10,
		S_PK_RD   = 23'd1 << 11,
		S_PK_LD   = 23'd1 << 12,
		S_DIV_A   = 23'd1 << 13,
		S_WAIT_A  = 23'd1 << 14,
		S_DIV_B   = 23'd1 << 15,
		S_WAIT_B  = 23'd1 << 16,
		S_DIV_C   = 23'd1 << 17,
		S_WAIT_C  = 23'd1 << 18,
		S_UPD     = 23'd1 << 19,
		S_EM_RD   = 23'd1 << 20,
		S_EM_LD   = 23'd1 << 21,
		S_EM_WAIT = 23'd1 << 22
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   zmode_q;
	logic   zmode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			zmode_q <= 1'b0;
		end else begin
			state_q <= state_d;
			zmode_q <= zmode_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_IDX;
		cmd.div_op = DIV_B;
		state_d = state_q;
		zmode_d = zmode_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (item_valid) begin
					cmd.take_item = 1'b1;
					if (item_mode) begin
						cmd.idx_clr = 1'b1;
						cmd.sum_clr = 1'b1;
						state_d = S_INIT_RD;
					end else begin
						state_d = S_LD_RD;
					end
				end
			end
			S_LD_RD: begin
				cmd.rd_sel = RD_CH;
				state_d = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.tot_wr = 1'b1;
				state_d = S_IDLE;
			end
			S_INIT_RD: state_d = S_INIT_WR;
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				if (sts.idx_last) begin
					state_d = S_CHECK;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_INIT_RD;
				end
			end
			S_CHECK: begin
				cmd.idx_clr = 1'b1;
				if (sts.sum_ge) begin
					cmd.max_clr = 1'b1;
					state_d = S_MAX_RD;
				end else begin
					state_d = S_EM_RD;
				end
			end
			S_MAX_RD: state_d = S_MAX_CMP;
			S_MAX_CMP: begin
				cmd.max_cmp = 1'b1;
				if (sts.idx_last) begin
					state_d = S_MAX_END;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_MAX_RD;
				end
			end
			S_MAX_END: begin
				zmode_d = 1'b0;
				if (sts.best_zero) begin
					cmd.idx_clr = 1'b1;
					state_d = S_NZ_RD;
				end else begin
					state_d = S_PK_RD;
				end
			end
			S_NZ_RD: state_d = S_NZ_CMP;
			S_NZ_CMP: begin
				// No split shrinks anything: jump the first nonzero channel ahead.
				if (sts.size_nz) begin
					cmd.pick_idx = 1'b1;
					zmode_d = 1'b1;
					state_d = S_PK_RD;
				end else if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d = S_EM_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_NZ_RD;
				end
			end
			S_PK_RD: begin
				cmd.rd_sel = RD_PICK;
				state_d = S_PK_LD;
			end
			S_PK_LD: begin
				cmd.pk_load = 1'b1;
				cmd.pk_inc = !zmode_q;
				state_d = zmode_q ? S_DIV_A : S_DIV_B;
			end
			S_DIV_A: begin
				cmd.div_op = DIV_A;
				cmd.div_start = 1'b1;
				state_d = S_WAIT_A;
			end
			S_WAIT_A: begin
				cmd.div_op = DIV_A;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d = S_DIV_B;
				end
			end
			S_DIV_B: begin
				cmd.div_op = DIV_B;
				cmd.div_start = 1'b1;
				state_d = S_WAIT_B;
			end
			S_WAIT_B: begin
				cmd.div_op = DIV_B;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d = S_DIV_C;
				end
			end
			S_DIV_C: begin
				cmd.div_op = DIV_C;
				cmd.div_start = 1'b1;
				state_d = S_WAIT_C;
			end
			S_WAIT_C: begin
				cmd.div_op = DIV_C;
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd_wr = 1'b1;
				state_d = S_CHECK;
			end
			S_EM_RD: state_d = S_EM_LD;
			S_EM_LD: begin
				cmd.out_load = 1'b1;
				state_d = S_EM_WAIT;
			end
			S_EM_WAIT: begin
				if (sts.out_taken) begin
					if (sts.idx_last) begin
						cmd.clear_valid = 1'b1;
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = S_EM_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[hdl/greedy_buffer_split_allocator.sv]
// Greedy buffer split allocator top level; one-read-port tables and a shared serial divider.
// A load word is accepted, its total read from the table and the saturating sum written back.
// A run word seeds N channels, then per split scans, picks and updates with two divider passes,
// or with three passes after a search for a nonzero size when no split shrinks any size;
// then it emits one result per channel, each held until the receiver takes it.
// Reset is asynchronous: all totals read as zero, the budget is 41943040, the count is 64.
`default_nettype none
module greedy_buffer_split_allocator import gbsa_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	gbsa_item_if.sink   item,
	gbsa_result_if.source result,
	gbsa_cfg_if.sink    cfg
);
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign item.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	gbsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .item_valid(item.valid), .item_mode(item.mode),
		.sts(sts), .cmd(cmd)
	);

	gbsa_datapath u_datapath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.item_channel(item.channel_index), .item_bytes(item.byte_count),
		.cfg_valid(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.res_valid(result.valid), .res_ready(result.ready),
		.res_channel(result.out_channel), .res_size(result.buffer_size),
		.res_splits(result.split_count), .res_last(result.last_result)
	);
endmodule
`default_nettype wire

[tb/sv/tb_greedy_buffer_split_allocator.sv]
// Self-checking testbench for the greedy buffer split allocator.
`default_nettype none
module tb_greedy_buffer_split_allocator;
	import gbsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              mode;
		logic [CH_W-1:0]   channel;
		logic [DATA_W-1:0] bytes;
	} load_word_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [DATA_W-1:0] size;
		logic [DATA_W-1:0] splits;
		logic              last;
	} alloc_word_t;

	typedef struct packed {
		reg_idx_t          idx;
		logic [DATA_W-1:0] data;
	} reg_word_t;

	localparam int STALL_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	gbsa_item_if   item_ch();
	gbsa_result_if result_ch();
	gbsa_cfg_if    cfg_ch();

	greedy_buffer_split_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	load_word_t  pending_words[$];
	reg_word_t   pending_regs[$];
	alloc_word_t expected_allocs[$];

	// Predictor state.
	logic [DATA_W-1:0] budget_q;
	logic [CNT_W-1:0]  count_q;
	logic [DATA_W-1:0] total_q[MAX_CHANNELS];

	int send_idle_pct;
	int recv_stall_pct;
	int holds_asked;
	int holds_done;
	int hold_left;
	int errors;
	int words_sent;
	int runs_sent;
	int allocs_seen;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic longint unsigned gain_of(longint unsigned t, longint unsigned k);
		return t / k - t / (k + 1);
	endfunction

	// Greedy split over the channels in use; queues one expected word per channel.
	function automatic void predict_allocation();
		int n;
		int pick;
		bit found;
		longint unsigned sum;
		longint unsigned best;
		longint unsigned k[MAX_CHANNELS];
		longint unsigned g[MAX_CHANNELS];
		logic [DATA_W-1:0] sz[MAX_CHANNELS];
		logic [DATA_W-1:0] old_sz;
		logic [DATA_W-1:0] s;
		alloc_word_t w;
		n = (count_q == 0) ? 1 : (count_q > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_q);
		sum = 0;
		for (int i = 0; i < n; i++) begin
			sz[i] = total_q[i];
			k[i] = 64'd1;
			g[i] = gain_of(64'(total_q[i]), 64'd1);
			sum += 64'(total_q[i]);
		end
		while (sum >= 64'(budget_q)) begin
			pick = 0;
			best = g[0];
			for (int i = 1; i < n; i++)
				if (g[i] > best) begin
					best = g[i];
					pick = i;
				end
			if (best == 0) begin
				found = 0;
				for (int i = 0; i < n && !found; i++)
					if (sz[i] != 0) begin
						found = 1;
						pick = i;
					end
				if (!found)
					break;
				// Jump to the last split count that still gives the same size.
				k[pick] = 64'(total_q[pick]) / 64'(sz[pick]);
				g[pick] = gain_of(64'(total_q[pick]), k[pick]);
				continue;
			end
			old_sz = sz[pick];
			k[pick] += 1;
			sz[pick] = DATA_W'(64'(total_q[pick]) / k[pick]);
			sum -= 64'(old_sz - sz[pick]);
			g[pick] = gain_of(64'(total_q[pick]), k[pick]);
		end
		for (int i = 0; i < n; i++) begin
			s = (sz[i] == 0) ? MIN_BUFFER : sz[i];
			w.channel = CH_W'(i);
			w.size = s & ALIGN_MASK;
			w.splits = (k[i] > 64'hFFFF_FFFF) ? '1 : DATA_W'(k[i]);
			w.last = (i == n - 1);
			expected_allocs = {expected_allocs, w};
		end
		for (int i = 0; i < MAX_CHANNELS; i++)
			total_q[i] = '0;
	endfunction

	function automatic void predict_word(load_word_t w);
		longint unsigned t;
		if (w.mode) begin
			predict_allocation();
		end else begin
			t = 64'(total_q[w.channel]) + 64'(w.bytes);
			total_q[w.channel] = (t > 64'hFFFF_FFFF) ? '1 : DATA_W'(t);
		end
	endfunction

	// Item driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.mode <= 1'b0;
			item_ch.channel_index <= '0;
			item_ch.byte_count <= '0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				load_word_t w;
				w = pending_words.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.mode <= w.mode;
				item_ch.channel_index <= w.channel;
				item_ch.byte_count <= w.bytes;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Register write driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= REG_BUDGET;
			cfg_ch.data <= '0;
		end else if (!cfg_ch.valid || cfg_ch.ready) begin
			if (pending_regs.size() > 0) begin
				reg_word_t r;
				r = pending_regs.pop_front();
				cfg_ch.valid <= 1'b1;
				cfg_ch.index <= r.idx;
				cfg_ch.data <= r.data;
			end else begin
				cfg_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver; a requested hold-off starts once a result word is waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			holds_done <= 0;
			hold_left <= 0;
		end else if (holds_asked != holds_done && result_ch.valid) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: prediction on accepted words, checking of results, watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_BUDGET)
					budget_q = cfg_ch.data;
				else
					count_q = cfg_ch.data[CNT_W-1:0];
			end
			if (item_ch.valid && item_ch.ready) begin
				load_word_t w;
				w.mode = item_ch.mode;
				w.channel = item_ch.channel_index;
				w.bytes = item_ch.byte_count;
				predict_word(w);
			end
			if (result_ch.valid && result_ch.ready) begin
				alloc_word_t got;
				alloc_word_t want;
				got.channel = result_ch.out_channel;
				got.size = result_ch.buffer_size;
				got.splits = result_ch.split_count;
				got.last = result_ch.last_result;
				allocs_seen++;
				if (expected_allocs.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h", $time, got);
				end else begin
					want = expected_allocs.pop_front();
					if (got.channel !== want.channel)
						$display("%0t: out_channel expected %0d actual %0d",
							$time, want.channel, got.channel);
					if (got.size !== want.size)
						$display("%0t: buffer_size expected %0d actual %0d",
							$time, want.size, got.size);
					if (got.splits !== want.splits)
						$display("%0t: split_count expected %0d actual %0d",
							$time, want.splits, got.splits);
					if (got.last !== want.last)
						$display("%0t: last_result expected %0b actual %0b",
							$time, want.last, got.last);
					if (got !== want)
						errors++;
				end
			end
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL greedy_buffer_split_allocator");
				$finish;
			end
		end
	end

	task automatic add_load(int ch, logic [DATA_W-1:0] bytes);
		load_word_t w;
		w.mode = 1'b0;
		w.channel = CH_W'(ch);
		w.bytes = bytes;
		pending_words = {pending_words, w};
		words_sent++;
	endtask

	task automatic add_run();
		load_word_t w;
		w.mode = 1'b1;
		w.channel = CH_W'($urandom_range(63));
		w.bytes = $urandom;
		pending_words = {pending_words, w};
		words_sent++;
		runs_sent++;
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || item_ch.valid || expected_allocs.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Registers change only while the block is idle.
	task automatic set_regs(logic [DATA_W-1:0] budget, logic [DATA_W-1:0] count);
		reg_word_t r;
		drain();
		r.idx = REG_BUDGET;
		r.data = budget;
		pending_regs = {pending_regs, r};
		r.idx = REG_COUNT;
		r.data = count;
		pending_regs = {pending_regs, r};
		while (pending_regs.size() > 0 || cfg_ch.valid)
			@(posedge clk);
	endtask

	task automatic pick_idling(int phase);
		case (phase % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 50;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 50;
			end
			default: begin
				send_idle_pct = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	initial begin
		int phase;
		int n;
		int loads;
		budget_q = BUDGET_RST;
		count_q = COUNT_RST;
		for (int i = 0; i < MAX_CHANNELS; i++)
			total_q[i] = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holds_asked = 0;
		errors = 0;
		words_sent = 0;
		runs_sent = 0;
		allocs_seen = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, a saturating total and the top channel.
		add_load(0, '1);
		add_load(0, '1);
		add_load(63, 32'd12345);
		add_load(5, 32'd0);
		add_run();
		// Largest budget, one channel in use, a load beyond the count.
		set_regs('1, 32'd1);
		add_load(0, '1);
		add_load(40, 32'd99);
		add_run();
		// Budget of one: splitting runs until every size is zero.
		set_regs(32'd1, 32'd2);
		add_load(0, 32'd40);
		add_load(1, 32'd7);
		add_run();
		// Budget zero and a count of zero, then a run with every total zero.
		set_regs(32'd0, 32'd0);
		add_load(0, 32'd30);
		add_run();
		add_run();
		// A count above the channel limit.
		set_regs(32'd1000, 32'h7F);
		add_load(10, 32'd2000);
		add_load(63, 32'd600);
		add_run();

		phase = 0;
		while (words_sent < 350) begin
			pick_idling(phase);
			if (phase == 0 || $urandom_range(2) != 0) begin
				n = ($urandom_range(7) == 0) ? MAX_CHANNELS : int'($urandom_range(1, 8));
				set_regs(DATA_W'($urandom_range(1 << 18, 1 << 24)), DATA_W'(n));
			end else begin
				drain();
				n = (count_q == 0) ? 1 : (count_q > MAX_CHANNELS) ? MAX_CHANNELS
					: int'(count_q);
			end
			loads = $urandom_range(4, 14);
			for (int i = 0; i < loads; i++)
				add_load(($urandom_range(9) < 7) ? $urandom_range(n - 1) : $urandom_range(63),
					$urandom_range(65535));
			if (phase == 1) begin
				// Hold results back while loads pile up behind the run.
				holds_asked <= holds_asked + 1;
				add_run();
				for (int i = 0; i < 12; i++)
					add_load($urandom_range(n - 1), $urandom_range(65535));
				add_run();
			end else begin
				add_run();
			end
			phase++;
		end
		drain();
		repeat (200) @(posedge clk);

		$display("Sent %0d words including %0d runs, checked %0d allocation words.",
			words_sent, runs_sent, allocs_seen);
		$display("Covered saturation, budget and count extremes, stalls and long hold-offs.");
		if (errors == 0 && expected_allocs.size() == 0)
			$display("PASS greedy_buffer_split_allocator");
		else
			$display("FAIL greedy_buffer_split_allocator");
		$finish;
	end
endmodule
`default_nettype wire
